[src/ftb_pkg.sv]
package ftb_pkg;

	localparam int unsigned MAX_TIMERS_DEF    = 16;
	localparam int unsigned PENDING_DEPTH_DEF = 16;

	// Input modes
	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	// Result kinds
	localparam logic [2:0] KIND_FRAME    = 3'd0;
	localparam logic [2:0] KIND_FIRED    = 3'd1;
	localparam logic [2:0] KIND_ADDED    = 3'd2;
	localparam logic [2:0] KIND_REMOVED  = 3'd3;
	localparam logic [2:0] KIND_REJECTED = 3'd4;

	// Register indexes (paddr[2])
	localparam logic REG_TPS = 1'b0;
	localparam logic REG_MDT = 1'b1;

	localparam logic [31:0] TPS_RESET  = 32'd10000000;
	localparam logic [31:0] MDT_RESET  = 32'd1000000;
	localparam logic [32:0] WIN_MAX    = '1;
	localparam logic [31:0] ACC_MAX    = '1;
	localparam logic [15:0] FRAMES_MAX = '1;

	typedef enum logic [1:0] {
		CLS_TICK,
		CLS_ADD,
		CLS_REMOVE
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic [31:0] elapsed_ticks;
		logic [31:0] interval_ticks;
		logic        repeat_req;
		logic [15:0] timer_id;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] timer_id_res;
		logic [31:0] clamped_delta;
		logic [15:0] fps;
		logic        last;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WIN,
		ST_FPS,
		ST_REPORT,
		ST_COMPACT,
		ST_APPEND,
		ST_SUM,
		ST_FIRE,
		ST_ADD,
		ST_REMOVE,
		ST_END
	} state_t;

endpackage

[src/ftb_if.sv]
interface ftb_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] elapsed_ticks;
	logic [31:0] interval_ticks;
	logic        repeat_req;
	logic [15:0] timer_id;

	modport source (output valid, mode, elapsed_ticks, interval_ticks, repeat_req, timer_id,
		input ready);
	modport sink (input valid, mode, elapsed_ticks, interval_ticks, repeat_req, timer_id,
		output ready);
endinterface

interface ftb_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] timer_id_res;
	logic [31:0] clamped_delta;
	logic [15:0] fps;
	logic        last;

	modport source (output valid, kind, timer_id_res, clamped_delta, fps, last,
		input ready);
	modport sink (input valid, kind, timer_id_res, clamped_delta, fps, last,
		output ready);
endinterface

[src/frame_tick_timer_bank.sv]
// Add and remove requests go through the front queue, ST_ADD or ST_REMOVE into
// staging and ST_END into the output register, waiting while results stall.
// Frame tick: window, fps, report, then A active timers walked for removal, P
// pending additions appended, T timers summed and checked, one at a time.
// The front queue holds two requests, so requests are taken while a tick runs.
// Reset clears counts, frame window, ids and registers to their defaults;
// timer and queue tables hold no reset and are only read below their counts.
module frame_tick_timer_bank #(
	parameter int unsigned MAX_TIMERS    = ftb_pkg::MAX_TIMERS_DEF,
	parameter int unsigned PENDING_DEPTH = ftb_pkg::PENDING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ftb_in_if.sink      in_ch,
	ftb_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0]    tps_q;
	logic [31:0]    mdt_q;
	ftb_pkg::head_t head;
	logic           pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ftb_pkg::REG_MDT) ? mdt_q : tps_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= ftb_pkg::TPS_RESET;
			mdt_q <= ftb_pkg::MDT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == ftb_pkg::REG_MDT) mdt_q <= pwdata;
			else                              tps_q <= pwdata;
		end
	end

	ftb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.head   (head),
		.pop    (pop)
	);

	ftb_back #(
		.MAX_TIMERS    (MAX_TIMERS),
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.tps    (tps_q),
		.mdt    (mdt_q),
		.out_ch (out_ch)
	);

endmodule

[src/ftb_front.sv]
module ftb_front (
	input  logic            clk,
	input  logic            arst_n,
	ftb_in_if.sink          in_ch,
	output ftb_pkg::head_t  head,
	input  logic            pop
);

	ftb_pkg::item_t q_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           push;
	ftb_pkg::item_t item;

	assign in_ch.ready = (cnt_q != 2'd2);

	// Classify the request; the undefined mode is dropped here
	always_comb begin
		item.elapsed_ticks  = in_ch.elapsed_ticks;
		item.interval_ticks = in_ch.interval_ticks;
		item.repeat_req     = in_ch.repeat_req;
		item.timer_id       = in_ch.timer_id;
		push                = in_ch.valid && in_ch.ready;
		unique case (in_ch.mode)
			ftb_pkg::MODE_TICK:   item.cls = ftb_pkg::CLS_TICK;
			ftb_pkg::MODE_ADD:    item.cls = ftb_pkg::CLS_ADD;
			ftb_pkg::MODE_REMOVE: item.cls = ftb_pkg::CLS_REMOVE;
			default: begin
				item.cls = ftb_pkg::CLS_TICK;
				push     = 1'b0;
			end
		endcase
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = q_q[rp_q];

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Hold queued items
	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= item;
	end

endmodule

[src/ftb_back.sv]
module ftb_back #(
	parameter int unsigned MAX_TIMERS    = ftb_pkg::MAX_TIMERS_DEF,
	parameter int unsigned PENDING_DEPTH = ftb_pkg::PENDING_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ftb_pkg::head_t  head,
	output logic            pop,
	input  logic [31:0]     tps,
	input  logic [31:0]     mdt,
	ftb_out_if.source       out_ch
);

	localparam int unsigned AW  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int unsigned ACW = $clog2(MAX_TIMERS + 1);
	localparam int unsigned PW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int unsigned PCW = $clog2(PENDING_DEPTH + 1);

	ftb_pkg::state_t state_q, state_d;
	ftb_pkg::item_t  cur_q;

	logic [31:0] delta_q;
	logic [15:0] frames_q;
	logic [32:0] win_q;
	logic [15:0] fps_q;
	logic [15:0] next_id_q;

	logic [15:0] act_id_q   [MAX_TIMERS];
	logic [31:0] act_intv_q [MAX_TIMERS];
	logic [31:0] act_acc_q  [MAX_TIMERS];
	logic        act_rep_q  [MAX_TIMERS];
	logic [ACW-1:0] act_cnt_q;

	logic [15:0] add_id_q   [PENDING_DEPTH];
	logic [31:0] add_intv_q [PENDING_DEPTH];
	logic        add_rep_q  [PENDING_DEPTH];
	logic [PCW-1:0] add_cnt_q;
	logic [15:0] rm_id_q    [PENDING_DEPTH];
	logic [PCW-1:0] rm_cnt_q;

	logic [ACW-1:0] i_q, w_q;
	logic [PCW-1:0] j_q;
	logic [31:0]    sum_q;

	ftb_pkg::res_t pend_q, out_q, emit_res;
	logic          pend_v_q, out_v_q;

	logic          out_free, can_emit, emit;
	logic [AW-1:0] idx;
	logic          rm_hit, fire, add_full, rm_full, append_go;
	logic [33:0]   win_sum;
	logic [32:0]   acc_sum;

	assign out_free = !out_v_q || out_ch.ready;
	assign can_emit = !pend_v_q || out_free;
	assign idx      = i_q[AW-1:0];
	assign add_full = (add_cnt_q >= PCW'(PENDING_DEPTH));
	assign rm_full  = (rm_cnt_q >= PCW'(PENDING_DEPTH));
	assign win_sum  = {1'b0, win_q} + {2'b0, delta_q};
	assign acc_sum  = {1'b0, act_acc_q[idx]} + {1'b0, delta_q};
	assign fire     = (sum_q >= act_intv_q[idx]);
	assign append_go = (j_q < add_cnt_q) && (act_cnt_q < ACW'(MAX_TIMERS));

	// Match the current timer against queued removals
	always_comb begin
		rm_hit = 1'b0;
		for (int k = 0; k < PENDING_DEPTH; k++) begin
			if ((PCW'(k) < rm_cnt_q) && (rm_id_q[k] == act_id_q[idx])) rm_hit = 1'b1;
		end
	end

	// Next state and result selection
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		emit     = 1'b0;
		emit_res = '0;
		unique case (state_q)
			ftb_pkg::ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					unique case (head.item.cls)
						ftb_pkg::CLS_TICK:   state_d = ftb_pkg::ST_WIN;
						ftb_pkg::CLS_ADD:    state_d = ftb_pkg::ST_ADD;
						ftb_pkg::CLS_REMOVE: state_d = ftb_pkg::ST_REMOVE;
						default:             state_d = ftb_pkg::ST_IDLE;
					endcase
				end
			end
			ftb_pkg::ST_WIN: state_d = ftb_pkg::ST_FPS;
			ftb_pkg::ST_FPS: state_d = ftb_pkg::ST_REPORT;
			ftb_pkg::ST_REPORT: begin
				emit_res.kind          = ftb_pkg::KIND_FRAME;
				emit_res.clamped_delta = delta_q;
				emit_res.fps           = fps_q;
				if (can_emit) begin
					emit    = 1'b1;
					state_d = ftb_pkg::ST_COMPACT;
				end
			end
			ftb_pkg::ST_COMPACT: begin
				if (i_q >= act_cnt_q) state_d = ftb_pkg::ST_APPEND;
			end
			ftb_pkg::ST_APPEND: begin
				if (!append_go) state_d = ftb_pkg::ST_SUM;
			end
			ftb_pkg::ST_SUM: begin
				state_d = (i_q < act_cnt_q) ? ftb_pkg::ST_FIRE : ftb_pkg::ST_END;
			end
			ftb_pkg::ST_FIRE: begin
				emit_res.kind         = ftb_pkg::KIND_FIRED;
				emit_res.timer_id_res = act_id_q[idx];
				if (!fire) begin
					state_d = ftb_pkg::ST_SUM;
				end else if (can_emit) begin
					emit    = 1'b1;
					state_d = ftb_pkg::ST_SUM;
				end
			end
			ftb_pkg::ST_ADD: begin
				emit_res.kind         = add_full ? ftb_pkg::KIND_REJECTED : ftb_pkg::KIND_ADDED;
				emit_res.timer_id_res = add_full ? 16'd0 : next_id_q;
				if (can_emit) begin
					emit    = 1'b1;
					state_d = ftb_pkg::ST_END;
				end
			end
			ftb_pkg::ST_REMOVE: begin
				emit_res.kind         = rm_full ? ftb_pkg::KIND_REJECTED : ftb_pkg::KIND_REMOVED;
				emit_res.timer_id_res = cur_q.timer_id;
				if (can_emit) begin
					emit    = 1'b1;
					state_d = ftb_pkg::ST_END;
				end
			end
			ftb_pkg::ST_END: begin
				if (out_free) state_d = ftb_pkg::ST_IDLE;
			end
			default: state_d = ftb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ftb_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Control state: counts, window, ids and result staging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_cnt_q <= '0;
			add_cnt_q <= '0;
			rm_cnt_q  <= '0;
			next_id_q <= '0;
			frames_q  <= '0;
			win_q     <= '0;
			fps_q     <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
			i_q       <= '0;
			w_q       <= '0;
			j_q       <= '0;
		end else begin
			// Load the output register from staging, else drain it
			if ((emit && pend_v_q) ||
				(state_q == ftb_pkg::ST_END && out_free && pend_v_q)) out_v_q <= 1'b1;
			else if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			if (emit) pend_v_q <= 1'b1;
			unique case (state_q)
				ftb_pkg::ST_WIN: begin
					if (frames_q != ftb_pkg::FRAMES_MAX) frames_q <= frames_q + 16'd1;
					win_q <= win_sum[33] ? ftb_pkg::WIN_MAX : win_sum[32:0];
				end
				ftb_pkg::ST_FPS: begin
					if (win_q >= {1'b0, tps}) begin
						fps_q    <= frames_q;
						win_q    <= win_q - {1'b0, tps};
						frames_q <= '0;
					end
					i_q <= '0;
					w_q <= '0;
				end
				ftb_pkg::ST_COMPACT: begin
					if (i_q < act_cnt_q) begin
						i_q <= i_q + ACW'(1);
						if (!rm_hit) w_q <= w_q + ACW'(1);
					end else begin
						act_cnt_q <= w_q;
						rm_cnt_q  <= '0;
						j_q       <= '0;
					end
				end
				ftb_pkg::ST_APPEND: begin
					if (append_go) begin
						act_cnt_q <= act_cnt_q + ACW'(1);
						j_q       <= j_q + PCW'(1);
					end else begin
						add_cnt_q <= '0;
						i_q       <= '0;
					end
				end
				ftb_pkg::ST_FIRE: begin
					if (!fire || can_emit) i_q <= i_q + ACW'(1);
				end
				ftb_pkg::ST_ADD: begin
					if (can_emit && !add_full) begin
						add_cnt_q <= add_cnt_q + PCW'(1);
						next_id_q <= next_id_q + 16'd1;
					end
				end
				ftb_pkg::ST_REMOVE: begin
					if (can_emit && !rm_full) rm_cnt_q <= rm_cnt_q + PCW'(1);
				end
				ftb_pkg::ST_END: begin
					if (out_free && pend_v_q) pend_v_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Payload: timer tables, queues and result registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q   <= head.item;
			delta_q <= (head.item.elapsed_ticks > mdt) ? mdt : head.item.elapsed_ticks;
		end
		if (emit) begin
			if (pend_v_q) out_q <= pend_q;
			pend_q <= emit_res;
		end
		unique case (state_q)
			ftb_pkg::ST_COMPACT: begin
				if ((i_q < act_cnt_q) && !rm_hit) begin
					act_id_q[w_q[AW-1:0]]   <= act_id_q[idx];
					act_intv_q[w_q[AW-1:0]] <= act_intv_q[idx];
					act_acc_q[w_q[AW-1:0]]  <= act_acc_q[idx];
					act_rep_q[w_q[AW-1:0]]  <= act_rep_q[idx];
				end
			end
			ftb_pkg::ST_APPEND: begin
				if (append_go) begin
					act_id_q[act_cnt_q[AW-1:0]]   <= add_id_q[j_q[PW-1:0]];
					act_intv_q[act_cnt_q[AW-1:0]] <= add_intv_q[j_q[PW-1:0]];
					act_rep_q[act_cnt_q[AW-1:0]]  <= add_rep_q[j_q[PW-1:0]];
					act_acc_q[act_cnt_q[AW-1:0]]  <= '0;
				end
			end
			ftb_pkg::ST_SUM: begin
				sum_q <= acc_sum[32] ? ftb_pkg::ACC_MAX : acc_sum[31:0];
			end
			ftb_pkg::ST_FIRE: begin
				if (!fire) act_acc_q[idx] <= sum_q;
				else if (can_emit)
					act_acc_q[idx] <= act_rep_q[idx] ? (sum_q - act_intv_q[idx]) : sum_q;
			end
			ftb_pkg::ST_ADD: begin
				if (can_emit && !add_full) begin
					add_id_q[add_cnt_q[PW-1:0]]   <= next_id_q;
					add_intv_q[add_cnt_q[PW-1:0]] <= cur_q.interval_ticks;
					add_rep_q[add_cnt_q[PW-1:0]]  <= cur_q.repeat_req;
				end
			end
			ftb_pkg::ST_REMOVE: begin
				if (can_emit && !rm_full) rm_id_q[rm_cnt_q[PW-1:0]] <= cur_q.timer_id;
			end
			ftb_pkg::ST_END: begin
				// Mark the final result of the request
				if (out_free && pend_v_q)
					out_q <= {pend_q[$bits(ftb_pkg::res_t)-1:1], 1'b1};
			end
			default: ;
		endcase
	end

	assign out_ch.valid         = out_v_q;
	assign out_ch.kind          = out_q.kind;
	assign out_ch.timer_id_res  = out_q.timer_id_res;
	assign out_ch.clamped_delta = out_q.clamped_delta;
	assign out_ch.fps           = out_q.fps;
	assign out_ch.last          = out_q.last;

endmodule

[src/ftb_checker.sv]
module ftb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [15:0] timer_id_res,
	input logic [31:0] clamped_delta,
	input logic [15:0] fps,
	input logic        last
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
		else $error("result dropped while stalled");

	// Frame reports carry no id
	a_frame_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == ftb_pkg::KIND_FRAME |-> timer_id_res == 16'd0)
		else $error("frame report with id");

	// Only frame reports carry delta and fps
	a_nonframe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != ftb_pkg::KIND_FRAME |-> clamped_delta == 32'd0 && fps == 16'd0)
		else $error("delta or fps outside frame report");

	// Add and remove requests give a single result
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == ftb_pkg::KIND_ADDED || kind == ftb_pkg::KIND_REMOVED ||
		kind == ftb_pkg::KIND_REJECTED) |-> last)
		else $error("request result not marked last");

endmodule

bind frame_tick_timer_bank ftb_checker u_ftb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.kind          (out_ch.kind),
	.timer_id_res  (out_ch.timer_id_res),
	.clamped_delta (out_ch.clamped_delta),
	.fps           (out_ch.fps),
	.last          (out_ch.last)
);
